@@ rtl/qfc_pkg.sv @@
// Shared types and constants for the quaternion fly camera update block.
// Holds the payload structs, controller states, datapath commands and fixed constants.
// Has no dependencies.
`default_nettype none

package qfc_pkg;

   // Input item: one frame tick.
   typedef struct packed {
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic               button_held;
      logic               key_forward;
      logic               key_back;
      logic               key_left;
      logic               key_right;
   } req_type;

   // Result item: position and orientation after the update.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } rsp_type;

   // Configuration register indexes.
   localparam logic CSR_ROTATE_GAIN = 1'b0;
   localparam logic CSR_MOVE_STEP   = 1'b1;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BRANCH,
      ST_ANGLE,
      ST_MOD,
      ST_FOLD,
      ST_CORDIC,
      ST_SAVE,
      ST_RPROD,
      ST_QPROD,
      ST_QCOMMIT,
      ST_MPROD,
      ST_DCALC,
      ST_DPROD,
      ST_FINISH
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_ANGLE,
      OP_MOD,
      OP_FOLD,
      OP_CORDIC,
      OP_SAVE,
      OP_RPROD,
      OP_QPROD,
      OP_QCOMMIT,
      OP_MPROD,
      OP_DCALC,
      OP_DPROD,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       axis;
      logic [4:0] idx;
   } cmd_type;

   typedef struct packed {
      logic button_held;
   } status_type;

   // First and last step indexes of the sequenced phases.
   localparam logic [4:0] MOD_FIRST    = 5'd12;
   localparam logic [4:0] CORDIC_LAST  = 5'd29;
   localparam logic [4:0] RPROD_LAST   = 5'd3;
   localparam logic [4:0] QPROD_LAST   = 5'd15;
   localparam logic [4:0] MPROD_LAST   = 5'd8;
   localparam logic [4:0] DPROD_LAST   = 5'd2;

   // Angle constants in Q.17 and CORDIC constants in Q2.30.
   localparam logic [19:0] TWO_PI_Q17  = 20'd823550;
   localparam logic [19:0] PI_Q17      = 20'd411775;
   localparam logic [19:0] HALF_PI_Q17 = 20'd205887;
   localparam logic [31:0] CORDIC_K    = 32'd652032874;
   localparam logic [31:0] ONE_Q30     = 32'd1073741824;

   // Reset values of the architectural state.
   localparam logic [15:0] GAIN_RESET   = 16'd655;
   localparam logic [15:0] STEP_RESET   = 16'd655;
   localparam logic [31:0] QUAT_W_RESET = 32'd1034781023;
   localparam logic [31:0] QUAT_Y_RESET = 32'hEEEA_8F67;
   localparam logic [31:0] POS_Z_RESET  = 32'd262144;

   // Arctangent table, Q2.30.
   localparam logic [31:0] ATAN_TAB [30] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

endpackage

`default_nettype wire

@@ rtl/qfc_datapath.sv @@
// Datapath of the fly camera: angle reduction, CORDIC, quaternion products and movement.
// Holds the configuration and camera state registers; driven by commands from qfc_ctrl.
// Depends on qfc_pkg.
`default_nettype none

module qfc_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire qfc_pkg::cmd_type    cmd,
   output qfc_pkg::status_type      status,
   input  wire qfc_pkg::req_type    req_data,
   output qfc_pkg::rsp_type         rsp_data,
   input  wire                  csr_write_en,
   input  wire                  csr_index,
   input  wire [15:0]           csr_wdata
);

   // Per product of the rotation: which stored component and whether it subtracts.
   localparam logic [1:0] QSEL [16] = '{
      2'd0, 2'd1, 2'd2, 2'd3,
      2'd1, 2'd0, 2'd3, 2'd2,
      2'd2, 2'd3, 2'd0, 2'd1,
      2'd3, 2'd2, 2'd1, 2'd0
   };
   localparam logic [15:0] QNEG = 16'b0100_0010_1000_1110;

   // Operand pairs of the rotation matrix products: yy zz xz wy xy wz yz wx xx.
   localparam logic [1:0] MSEL_A [9] = '{2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1};
   localparam logic [1:0] MSEL_B [9] = '{2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd1, 2'd1};

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sh0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -48'sh0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] r;
      p = a * b;
      r = (p + 64'sh2000_0000) >>> 30;
      return r[33:0];
   endfunction

   // Contribution of one key pair to a displacement: +c, -c or zero.
   function automatic logic signed [37:0] key_term(input logic pos, input logic neg,
                                                   input logic signed [36:0] c);
      logic signed [37:0] r;
      if (pos && !neg) begin
         r = 38'(c);
      end else if (neg && !pos) begin
         r = -38'(c);
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // Configuration and architectural state.
   logic        [15:0]       gain_ff, step_ff;
   logic signed [31:0]       quat_ff [4];
   logic signed [31:0]       pos_ff [3];
   logic signed [15:0]       last_x_ff, last_y_ff;
   qfc_pkg::req_type         item_ff;

   // Working registers.
   logic        [32:0]       amag_ff;
   logic                     aneg_ff;
   logic                     flip_ff;
   logic signed [33:0]       cx_ff, cy_ff;
   logic signed [34:0]       cz_ff;
   logic signed [31:0]       cos_ff [2];
   logic signed [31:0]       sin_ff [2];
   logic signed [31:0]       rq_ff [4];
   logic signed [36:0]       acc_ff;
   logic signed [31:0]       qn_ff [4];
   logic signed [33:0]       mp_ff [9];
   logic signed [37:0]       d_ff [3];
   qfc_pkg::rsp_type         rsp_ff;

   assign status.button_held = item_ff.button_held;
   assign rsp_data = rsp_ff;

   // Angle product: mouse delta times gain.
   logic signed [16:0] delta;
   logic signed [33:0] angle;
   always_comb begin
      if (cmd.axis) begin
         delta = 17'(item_ff.mouse_y) - 17'(last_y_ff);
      end else begin
         delta = 17'(item_ff.mouse_x) - 17'(last_x_ff);
      end
      angle = delta * $signed({1'b0, gain_ff});
   end

   // Modulo step and folding into the CORDIC range.
   logic [32:0]        mod_cmp;
   logic signed [21:0] r0, r1, r2;
   logic               flip;
   always_comb begin
      mod_cmp = 33'(qfc_pkg::TWO_PI_Q17) << cmd.idx[3:0];
      if (aneg_ff && amag_ff != '0) begin
         r0 = 22'(qfc_pkg::TWO_PI_Q17) - $signed(amag_ff[21:0]);
      end else begin
         r0 = $signed(amag_ff[21:0]);
      end
      if (r0 > $signed(22'(qfc_pkg::PI_Q17))) begin
         r1 = r0 - $signed(22'(qfc_pkg::TWO_PI_Q17));
      end else begin
         r1 = r0;
      end
      flip = 1'b1;
      if (r1 > $signed(22'(qfc_pkg::HALF_PI_Q17))) begin
         r2 = r1 - $signed(22'(qfc_pkg::PI_Q17));
      end else if (r1 < -$signed(22'(qfc_pkg::HALF_PI_Q17))) begin
         r2 = r1 + $signed(22'(qfc_pkg::PI_Q17));
      end else begin
         r2 = r1;
         flip = 1'b0;
      end
   end

   // One CORDIC rotation step.
   logic signed [33:0] cx_sh, cy_sh;
   logic signed [34:0] atan_step;
   always_comb begin
      cx_sh = cx_ff >>> cmd.idx;
      cy_sh = cy_ff >>> cmd.idx;
      atan_step = 35'($signed(qfc_pkg::ATAN_TAB[cmd.idx]));
   end

   // Shared Q2.30 multiplier and its operand selection.
   logic signed [31:0] mul_a, mul_b;
   logic signed [33:0] mp;
   logic [1:0]         sel_a, sel_b;
   always_comb begin
      sel_a = MSEL_A[4'(cmd.idx)];
      sel_b = MSEL_B[4'(cmd.idx)];
      case (cmd.op)
         qfc_pkg::OP_RPROD: begin
            mul_a = cmd.idx[1] ? sin_ff[0] : cos_ff[0];
            mul_b = cmd.idx[0] ? sin_ff[1] : cos_ff[1];
         end
         qfc_pkg::OP_QPROD: begin
            mul_a = rq_ff[cmd.idx[1:0]];
            mul_b = quat_ff[QSEL[cmd.idx[3:0]]];
         end
         qfc_pkg::OP_MPROD: begin
            mul_a = quat_ff[sel_a];
            mul_b = quat_ff[sel_b];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mp = mul30(mul_a, mul_b);
   end

   // Quaternion product accumulation.
   logic signed [36:0] term, acc_sum;
   always_comb begin
      term = QNEG[cmd.idx[3:0]] ? -37'(mp) : 37'(mp);
      acc_sum = (cmd.idx[1:0] == 2'd0) ? term : acc_ff + term;
   end

   // Rotation matrix columns of conj(q) and the displacement per axis.
   logic signed [36:0] c00, c02, c10, c12, c20, c22;
   logic signed [37:0] d_new [3];
   logic signed [36:0] one_q30;
   always_comb begin
      one_q30 = 37'(qfc_pkg::ONE_Q30);
      c00 = one_q30 - ((37'(mp_ff[0]) + 37'(mp_ff[1])) <<< 1);
      c02 = (37'(mp_ff[2]) - 37'(mp_ff[3])) <<< 1;
      c10 = (37'(mp_ff[4]) - 37'(mp_ff[5])) <<< 1;
      c12 = (37'(mp_ff[6]) + 37'(mp_ff[7])) <<< 1;
      c20 = (37'(mp_ff[2]) + 37'(mp_ff[3])) <<< 1;
      c22 = one_q30 - ((37'(mp_ff[8]) + 37'(mp_ff[0])) <<< 1);
      d_new[0] = key_term(item_ff.key_right, item_ff.key_left, c00)
               + key_term(item_ff.key_back, item_ff.key_forward, c02);
      d_new[1] = key_term(item_ff.key_right, item_ff.key_left, c10)
               + key_term(item_ff.key_back, item_ff.key_forward, c12);
      d_new[2] = key_term(item_ff.key_right, item_ff.key_left, c20)
               + key_term(item_ff.key_back, item_ff.key_forward, c22);
   end

   // Movement: scale one displacement by the step and add to the position.
   logic signed [54:0] move_prod, move_round;
   logic signed [47:0] pos_sum;
   logic [1:0]         pidx;
   always_comb begin
      pidx = cmd.idx[1:0];
      move_prod = d_ff[pidx] * $signed({1'b0, step_ff});
      move_round = (move_prod + 55'sh2000_0000) >>> 30;
      pos_sum = 48'(pos_ff[pidx]) + 48'(move_round);
   end

   // Configuration registers and camera state, set to their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= qfc_pkg::GAIN_RESET;
         step_ff    <= qfc_pkg::STEP_RESET;
         quat_ff[0] <= qfc_pkg::QUAT_W_RESET;
         quat_ff[1] <= '0;
         quat_ff[2] <= qfc_pkg::QUAT_Y_RESET;
         quat_ff[3] <= '0;
         pos_ff[0]  <= '0;
         pos_ff[1]  <= '0;
         pos_ff[2]  <= qfc_pkg::POS_Z_RESET;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
      end else begin
         if (csr_write_en && csr_index == qfc_pkg::CSR_ROTATE_GAIN) begin
            gain_ff <= csr_wdata;
         end
         if (csr_write_en && csr_index == qfc_pkg::CSR_MOVE_STEP) begin
            step_ff <= csr_wdata;
         end
         if (cmd.op == qfc_pkg::OP_QCOMMIT) begin
            quat_ff <= qn_ff;
         end
         if (cmd.op == qfc_pkg::OP_DPROD) begin
            pos_ff[pidx] <= sat32(pos_sum);
         end
         if (cmd.op == qfc_pkg::OP_DCALC) begin
            last_x_ff <= item_ff.mouse_x;
            last_y_ff <= item_ff.mouse_y;
         end
      end
   end

   // Working registers, written under command.
   always_ff @(posedge clock) begin
      case (cmd.op)
         qfc_pkg::OP_ACCEPT: begin
            item_ff <= req_data;
         end
         qfc_pkg::OP_ANGLE: begin
            aneg_ff <= angle[33];
            amag_ff <= angle[33] ? 33'(-angle) : angle[32:0];
         end
         qfc_pkg::OP_MOD: begin
            if (amag_ff >= mod_cmp) begin
               amag_ff <= amag_ff - mod_cmp;
            end
         end
         qfc_pkg::OP_FOLD: begin
            flip_ff <= flip;
            cx_ff   <= 34'(qfc_pkg::CORDIC_K);
            cy_ff   <= '0;
            cz_ff   <= 35'(r2) <<< 13;
         end
         qfc_pkg::OP_CORDIC: begin
            if (!cz_ff[34]) begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
               cz_ff <= cz_ff - atan_step;
            end else begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
               cz_ff <= cz_ff + atan_step;
            end
         end
         qfc_pkg::OP_SAVE: begin
            cos_ff[cmd.axis] <= sat32(flip_ff ? -48'(cx_ff) : 48'(cx_ff));
            sin_ff[cmd.axis] <= sat32(flip_ff ? -48'(cy_ff) : 48'(cy_ff));
         end
         qfc_pkg::OP_RPROD: begin
            rq_ff[cmd.idx[1:0]] <= sat32((cmd.idx[1:0] == 2'd3) ? -48'(mp) : 48'(mp));
         end
         qfc_pkg::OP_QPROD: begin
            acc_ff <= acc_sum;
            if (cmd.idx[1:0] == 2'd3) begin
               qn_ff[cmd.idx[3:2]] <= sat32(48'(acc_sum));
            end
         end
         qfc_pkg::OP_MPROD: begin
            mp_ff[4'(cmd.idx)] <= mp;
         end
         qfc_pkg::OP_DCALC: begin
            d_ff <= d_new;
         end
         qfc_pkg::OP_OUTPUT: begin
            rsp_ff.pos_x  <= pos_ff[0];
            rsp_ff.pos_y  <= pos_ff[1];
            rsp_ff.pos_z  <= pos_ff[2];
            rsp_ff.quat_w <= quat_ff[0];
            rsp_ff.quat_x <= quat_ff[1];
            rsp_ff.quat_y <= quat_ff[2];
            rsp_ff.quat_z <= quat_ff[3];
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/qfc_ctrl.sv @@
// Controller of the fly camera: sequences the datapath and runs both handshakes.
// Issues one command per cycle to qfc_datapath.
// Depends on qfc_pkg.
`default_nettype none

module qfc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output qfc_pkg::cmd_type      cmd,
   input  wire qfc_pkg::status_type status
);

   qfc_pkg::state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != qfc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State, step counter and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qfc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      cmd.op   = qfc_pkg::OP_NONE;
      cmd.idx  = cnt_ff;
      cmd.axis = axis_ff;
      case (state_ff)
         qfc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = qfc_pkg::OP_ACCEPT;
               state_in = qfc_pkg::ST_BRANCH;
            end
         end
         qfc_pkg::ST_BRANCH: begin
            cnt_in = '0;
            if (status.button_held) begin
               axis_in  = 1'b0;
               state_in = qfc_pkg::ST_ANGLE;
            end else begin
               state_in = qfc_pkg::ST_MPROD;
            end
         end
         qfc_pkg::ST_ANGLE: begin
            cmd.op   = qfc_pkg::OP_ANGLE;
            cnt_in   = qfc_pkg::MOD_FIRST;
            state_in = qfc_pkg::ST_MOD;
         end
         qfc_pkg::ST_MOD: begin
            cmd.op = qfc_pkg::OP_MOD;
            if (cnt_ff == '0) begin
               state_in = qfc_pkg::ST_FOLD;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         qfc_pkg::ST_FOLD: begin
            cmd.op   = qfc_pkg::OP_FOLD;
            cnt_in   = '0;
            state_in = qfc_pkg::ST_CORDIC;
         end
         qfc_pkg::ST_CORDIC: begin
            cmd.op = qfc_pkg::OP_CORDIC;
            if (cnt_ff == qfc_pkg::CORDIC_LAST) begin
               state_in = qfc_pkg::ST_SAVE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         qfc_pkg::ST_SAVE: begin
            cmd.op = qfc_pkg::OP_SAVE;
            cnt_in = '0;
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = qfc_pkg::ST_ANGLE;
            end else begin
               state_in = qfc_pkg::ST_RPROD;
            end
         end
         qfc_pkg::ST_RPROD: begin
            cmd.op = qfc_pkg::OP_RPROD;
            if (cnt_ff == qfc_pkg::RPROD_LAST) begin
               cnt_in   = '0;
               state_in = qfc_pkg::ST_QPROD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         qfc_pkg::ST_QPROD: begin
            cmd.op = qfc_pkg::OP_QPROD;
            if (cnt_ff == qfc_pkg::QPROD_LAST) begin
               state_in = qfc_pkg::ST_QCOMMIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         qfc_pkg::ST_QCOMMIT: begin
            cmd.op   = qfc_pkg::OP_QCOMMIT;
            cnt_in   = '0;
            state_in = qfc_pkg::ST_MPROD;
         end
         qfc_pkg::ST_MPROD: begin
            cmd.op = qfc_pkg::OP_MPROD;
            if (cnt_ff == qfc_pkg::MPROD_LAST) begin
               state_in = qfc_pkg::ST_DCALC;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         qfc_pkg::ST_DCALC: begin
            cmd.op   = qfc_pkg::OP_DCALC;
            cnt_in   = '0;
            state_in = qfc_pkg::ST_DPROD;
         end
         qfc_pkg::ST_DPROD: begin
            cmd.op = qfc_pkg::OP_DPROD;
            if (cnt_ff == qfc_pkg::DPROD_LAST) begin
               state_in = qfc_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         qfc_pkg::ST_FINISH: begin
            // Wait until the output register is free, then load it.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = qfc_pkg::OP_OUTPUT;
               state_in = qfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qfc_pkg::ST_IDLE;
         end
      endcase
   end

   // Output valid: set on a load, cleared once the transfer completes.
   always_comb begin
      if (cmd.op == qfc_pkg::OP_OUTPUT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

`ifndef SYNTHESIS
   a_accept_branches: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == qfc_pkg::ST_BRANCH))
      else $error("accepted item did not start processing");

   a_cordic_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qfc_pkg::ST_CORDIC) |-> (cnt_ff <= qfc_pkg::CORDIC_LAST))
      else $error("CORDIC step counter out of range");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == qfc_pkg::ST_FINISH))
      else $error("result presented outside the finish state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> (cmd.op != qfc_pkg::OP_OUTPUT))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ rtl/quaternion_fly_camera_update.sv @@
// With the button released only the matrix and movement steps run; when held, first
// two angle reductions of 13 steps and two 30-step CORDIC runs, then 29 multiplier steps.
// Items are processed one at a time; a single shared multiplier and CORDIC unit.
// A new item is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) restores gains, orientation, position and last mouse.
`default_nettype none

module quaternion_fly_camera_update (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire qfc_pkg::req_type   req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output qfc_pkg::rsp_type        rsp_data,
   input  wire                     csr_write_en,
   input  wire                     csr_index,
   input  wire [15:0]              csr_wdata
);

   qfc_pkg::cmd_type    cmd;
   qfc_pkg::status_type status;

   // Sequencer.
   qfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and state.
   qfc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire
